// ----- src/rbb_pkg.sv -----
// shared types for the rolling bollinger band core
`timescale 1ns / 1ps

package rbb_pkg;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_UPD  = 9'b000000010,
      S_MUL  = 9'b000000100,
      S_DIFF = 9'b000001000,
      S_DIVM = 9'b000010000,
      S_DIVV = 9'b000100000,
      S_SQRT = 9'b001000000,
      S_BAND = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

   localparam int unsigned FRAC_BITS = 8;
   localparam int unsigned VAR_FRAC_BITS = 16;
   localparam int unsigned MULT_BITS = 5;
   localparam int unsigned CFG_BITS = 7;
   localparam int unsigned CFG_RESET = 50;

endpackage

// ----- src/rbb_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rbb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/rolling_bollinger_band_core.sv -----
// rolling bollinger band core: ring, running sums, shared divider and root
`timescale 1ns / 1ps
// with a full window an accepted word passes the update, multiply, difference, mean division,
//    variance division, root, band and output states; while the window is still filling, update and output only
// the core takes a new word only when idle; the bit-serial divider runs twice, the root once
// the result register lets the next word in while a result still waits
// synchronous active-high reset: window empty, window length 50, no result pending
// ring contents are not cleared; an entry is read only after it was written

module rolling_bollinger_band_core #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   // input word, low bit up: sample[SAMPLE_BITS], band_multiple[5], zero pad
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((SAMPLE_BITS+5+7)/8)*8-1:0]       req_tdata,
   // result word, low bit up: band[SAMPLE_BITS], mean_q8[32], sigma_q8[32], zero pad
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((SAMPLE_BITS+64+7)/8)*8-1:0]      rsp_tdata,
   // result flags, low bit up: valid_res, saturated
   output logic [1:0]                               rsp_tuser,
   // window length register
   input  logic                                     csr_we,
   input  logic [rbb_pkg::CFG_BITS-1:0]             csr_wdata
);

   localparam int IW    = ((SAMPLE_BITS+5+7)/8)*8;
   localparam int OW    = ((SAMPLE_BITS+64+7)/8)*8;
   localparam int SB    = SAMPLE_BITS;
   localparam int WB    = $clog2(WINDOW_MAX+1);       // window length width
   localparam int PW    = $clog2(WINDOW_MAX);         // ring pointer width
   localparam int SUMW  = SB + WB;
   localparam int SQSW  = 2*SB + WB;
   localparam int DW    = 2*SB + 2*WB;                // n*sumsq - sum^2
   localparam int DENW  = 2*WB;                       // n*(n-1)
   localparam int NW    = DW + rbb_pkg::VAR_FRAC_BITS; // divider numerator / quotient
   localparam int SQW   = (NW+1)/2;                   // root width
   localparam int RADW  = 2*SQW;
   localparam int SRW   = SQW + 2;                    // root remainder width
   localparam int MW    = SB + rbb_pkg::FRAC_BITS;    // mean width
   localparam int TW    = SQW + 8;                    // band sum width
   localparam int CW    = $clog2(NW+1);
   localparam int NRST  = (rbb_pkg::CFG_RESET > WINDOW_MAX) ? WINDOW_MAX : rbb_pkg::CFG_RESET;
   localparam int MB    = rbb_pkg::MULT_BITS;

   rbb_pkg::state_type state_ff, state_in;

   // window state
   logic [WB-1:0]   n_ff, n_in;
   logic [PW-1:0]   wp_ff, wp_in;
   logic [WB-1:0]   seen_ff, seen_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [SQSW-1:0] sq_ff, sq_in;
   logic            full_ff, full_in;

   // captured word
   logic [SB-1:0]        smp_ff, smp_in;
   logic signed [MB-1:0] mult_ff, mult_in;

   // arithmetic registers
   logic [DW-1:0]   p1_ff, p1_in, p2_ff, p2_in, d_ff, d_in;
   logic [DENW-1:0] den_ff, den_in;
   logic [NW-1:0]   dq_ff, dq_in;
   logic [DENW:0]   dr_ff, dr_in;
   logic [DENW-1:0] dd_ff, dd_in;
   logic [RADW-1:0] rad_ff, rad_in;
   logic [SRW-1:0]  srem_ff, srem_in;
   logic [SQW-1:0]  root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [MW-1:0]   mean_ff, mean_in;

   // pending result, then output register
   logic [SB-1:0]   band_ff, band_in;
   logic            sat_ff, sat_in;
   logic            vres_ff, vres_in;
   logic            ovalid_ff, ovalid_in;
   logic [OW-1:0]   odata_ff, odata_in;
   logic [1:0]      ouser_ff, ouser_in;

   // ring
   logic [SB-1:0]   ring_rdata;
   logic            ring_we;

   rbb_ram #(.WIDTH(SB), .DEPTH(WINDOW_MAX)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (wp_ff),
      .wdata (smp_ff),
      .raddr (wp_ff),
      .rdata (ring_rdata)
   );

   // combinational helpers
   logic [SB-1:0]   old_s;
   logic [2*SB-1:0] old_sq, new_sq;
   logic [WB-1:0]   wp_inc, seen_inc;
   logic [DENW:0]   div_sh;
   logic            div_ge;
   logic [DENW:0]   div_rem;
   logic [NW-1:0]   div_quo;
   logic [SRW+1:0]  sq_sh, sq_trial;
   logic            sq_ge;
   logic signed [TW-1:0] t_mean, t_mult, t_sig, t_sum;
   logic            out_free;

   assign req_tready = (state_ff == rbb_pkg::S_IDLE);
   assign out_free   = !ovalid_ff || rsp_tready;

   assign old_s    = full_ff ? ring_rdata : '0;
   assign old_sq   = old_s * old_s;
   assign new_sq   = smp_ff * smp_ff;
   assign wp_inc   = WB'(wp_ff) + WB'(1);
   assign seen_inc = seen_ff + WB'(1);

   // restoring divider step, one quotient bit per cycle
   assign div_sh  = {dr_ff[DENW-1:0], dq_ff[NW-1]};
   assign div_ge  = (div_sh >= {1'b0, dd_ff});
   assign div_rem = div_ge ? (div_sh - {1'b0, dd_ff}) : div_sh;
   assign div_quo = {dq_ff[NW-2:0], div_ge};

   // root step, two radicand bits per cycle
   assign sq_sh    = {srem_ff, rad_ff[RADW-1 -: 2]};
   assign sq_trial = (SRW+2)'({root_ff, 2'b01});
   assign sq_ge    = (sq_sh >= sq_trial);

   // band sum
   assign t_mean = TW'(mean_ff);
   assign t_mult = TW'(mult_ff);
   assign t_sig  = TW'(root_ff);
   assign t_sum  = t_mean + t_mult * t_sig;

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      wp_in     = wp_ff;
      seen_in   = seen_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      full_in   = full_ff;
      smp_in    = smp_ff;
      mult_in   = mult_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      d_in      = d_ff;
      den_in    = den_ff;
      dq_in     = dq_ff;
      dr_in     = dr_ff;
      dd_in     = dd_ff;
      rad_in    = rad_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      mean_in   = mean_ff;
      band_in   = band_ff;
      sat_in    = sat_ff;
      vres_in   = vres_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      ouser_in  = ouser_ff;
      ring_we   = 1'b0;

      // result register drains independently
      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end

      case (state_ff)
         rbb_pkg::S_IDLE: begin
            if (req_tvalid) begin
               smp_in   = req_tdata[SB-1:0];
               mult_in  = req_tdata[SB+MB-1:SB];
               state_in = rbb_pkg::S_UPD;
            end
         end
         rbb_pkg::S_UPD: begin
            // drop the oldest sample once the window is full, add the new one
            ring_we = 1'b1;
            sum_in  = sum_ff - SUMW'(old_s) + SUMW'(smp_ff);
            sq_in   = sq_ff - SQSW'(old_sq) + SQSW'(new_sq);
            wp_in   = (wp_inc == n_ff) ? '0 : wp_inc[PW-1:0];
            if (!full_ff) begin
               seen_in = seen_inc;
            end
            full_in = full_ff || (seen_inc >= n_ff);
            if (full_ff || (seen_inc >= n_ff)) begin
               state_in = rbb_pkg::S_MUL;
            end else begin
               band_in  = '0;
               mean_in  = '0;
               root_in  = '0;
               sat_in   = 1'b0;
               vres_in  = 1'b0;
               state_in = rbb_pkg::S_OUT;
            end
         end
         rbb_pkg::S_MUL: begin
            p1_in    = n_ff * sq_ff;
            p2_in    = sum_ff * sum_ff;
            den_in   = DENW'(n_ff) * DENW'(n_ff - WB'(1));
            state_in = rbb_pkg::S_DIFF;
         end
         rbb_pkg::S_DIFF: begin
            d_in     = p1_ff - p2_ff;
            // mean division: (sum << 8) / n
            dq_in    = NW'({sum_ff, {rbb_pkg::FRAC_BITS{1'b0}}});
            dr_in    = '0;
            dd_in    = DENW'(n_ff);
            cnt_in   = CW'(NW);
            state_in = rbb_pkg::S_DIVM;
         end
         rbb_pkg::S_DIVM: begin
            dq_in  = div_quo;
            dr_in  = div_rem;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               mean_in  = div_quo[MW-1:0];
               // variance division: (d << 16) / (n*(n-1))
               dq_in    = {d_ff, {rbb_pkg::VAR_FRAC_BITS{1'b0}}};
               dr_in    = '0;
               dd_in    = den_ff;
               cnt_in   = CW'(NW);
               state_in = rbb_pkg::S_DIVV;
            end
         end
         rbb_pkg::S_DIVV: begin
            dq_in  = div_quo;
            dr_in  = div_rem;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               rad_in   = RADW'(div_quo);
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = CW'(SQW);
               state_in = rbb_pkg::S_SQRT;
            end
         end
         rbb_pkg::S_SQRT: begin
            rad_in = {rad_ff[RADW-3:0], 2'b00};
            if (sq_ge) begin
               srem_in = SRW'(sq_sh - sq_trial);
               root_in = {root_ff[SQW-2:0], 1'b1};
            end else begin
               srem_in = SRW'(sq_sh);
               root_in = {root_ff[SQW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = rbb_pkg::S_BAND;
            end
         end
         rbb_pkg::S_BAND: begin
            vres_in = 1'b1;
            if (t_sum[TW-1]) begin
               band_in = '0;
               sat_in  = 1'b1;
            end else if (t_sum[TW-2:8] > (TW-9)'({SB{1'b1}})) begin
               band_in = '1;
               sat_in  = 1'b1;
            end else begin
               band_in = t_sum[SB+7:8];
               sat_in  = 1'b0;
            end
            state_in = rbb_pkg::S_OUT;
         end
         rbb_pkg::S_OUT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = OW'({32'(root_ff), 32'(mean_ff), band_ff});
               ouser_in  = {sat_ff, vres_ff};
               state_in  = rbb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rbb_pkg::S_IDLE;
         end
      endcase

      // window length write clamps and empties the window
      if (csr_we) begin
         if (csr_wdata < rbb_pkg::CFG_BITS'(2)) begin
            n_in = WB'(2);
         end else if (int'(csr_wdata) > WINDOW_MAX) begin
            n_in = WB'(WINDOW_MAX);
         end else begin
            n_in = WB'(csr_wdata);
         end
         wp_in   = '0;
         seen_in = '0;
         sum_in  = '0;
         sq_in   = '0;
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rbb_pkg::S_IDLE;
         n_ff      <= WB'(NRST);
         wp_ff     <= '0;
         seen_ff   <= '0;
         sum_ff    <= '0;
         sq_ff     <= '0;
         full_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         n_ff      <= n_in;
         wp_ff     <= wp_in;
         seen_ff   <= seen_in;
         sum_ff    <= sum_in;
         sq_ff     <= sq_in;
         full_ff   <= full_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff   <= smp_in;
      mult_ff  <= mult_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      d_ff     <= d_in;
      den_ff   <= den_in;
      dq_ff    <= dq_in;
      dr_ff    <= dr_in;
      dd_ff    <= dd_in;
      rad_ff   <= rad_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      mean_ff  <= mean_in;
      band_ff  <= band_in;
      sat_ff   <= sat_in;
      vres_ff  <= vres_in;
      odata_ff <= odata_in;
      ouser_ff <= ouser_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;

endmodule

// ----- src/rbb_checker.sv -----
// port-level checker for the rolling bollinger band core, with its bind
`timescale 1ns / 1ps

module rbb_checker #(
   parameter int IN_W  = 32,
   parameter int OUT_W = 88
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [IN_W-1:0]  req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata,
   input logic [1:0]       rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // a clamp only happens on a full window
   a_sat_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("saturated without full window");

   // results before the window fills are all zero
   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0) && !rsp_tuser[1])
      else $error("nonzero result before window full");

   // an accepted word keeps the core busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // no result straight after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rolling_bollinger_band_core rbb_checker #(
   .IN_W  ($bits(req_tdata)),
   .OUT_W ($bits(rsp_tdata))
) u_rbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
